FILE: hdl/lphs_pkg.sv
package lphs_pkg;

    // Fixed field widths of the request and result words
    localparam int HASH_BITS      = 32;
    localparam int KEY_TYPE_BITS  = 4;
    localparam int SLOT_OUT_BITS  = 6;
    localparam int COUNT_OUT_BITS = 7;

    // Hash reduction works on this many bits a cycle
    localparam int CHUNK_BITS     = 8;

    // Request commands; the unused code behaves as a query
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SPARE  = 2'd3
    } t_command;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;        // write one empty slot of the clearing pass
        logic load;         // capture the request word, start the hash reduction
        logic probe_start;  // set the probe index to the home slot
        logic probe;        // examine one slot of the probe chain
        logic del;          // examine one slot of the backward shift
        logic del_end;      // empty the final hole
        logic out_load;     // load the result register
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;     // clearing pass is on its last slot
        logic home_done;    // home slot is ready
        logic probe_stop;   // probe chain ends on this slot
        logic del_go;       // the chain ended on a key to be removed
        logic del_stop;     // backward shift ends on this slot
        logic out_free;     // result register can take a new word
    } t_dp_sts;

endpackage

FILE: hdl/linear_probe_hash_set.sv
// Flow: each accepted input word gives one result word; a power-of-two table takes the home
// slot from the low hash bits, other table sizes reduce the hash modulo the table size, 8 bits
// a cycle. A remove that hits then walks a backward shift over the slots after its own.
// One request is in flight at a time; a stalled result holds off the next.
// Reset: synchronous, active low; then a clearing pass empties the table memory one slot a
// cycle with o_ready low.
module linear_probe_hash_set #(
    parameter int TABLE_SLOTS = 64,
    parameter int TYPE_BITS   = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_command,
    input  logic [lphs_pkg::KEY_TYPE_BITS-1:0]    i_key_type,
    input  logic [lphs_pkg::HASH_BITS-1:0]        i_key_hash,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_found,
    output logic [lphs_pkg::SLOT_OUT_BITS-1:0]    o_slot,
    output logic                                  o_status,
    output logic [lphs_pkg::COUNT_OUT_BITS-1:0]   o_count
);
    import lphs_pkg::*;

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    // Sequence the request through clear, probe, shift and result
    lphs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    // Table memory, hash reduction and result register
    lphs_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .TYPE_BITS   (TYPE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_command  (i_command),
        .i_key_type (i_key_type),
        .i_key_hash (i_key_hash),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_slot     (o_slot),
        .o_status   (o_status),
        .o_count    (o_count)
    );

endmodule

FILE: hdl/lphs_ctrl.sv
module lphs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lphs_pkg::t_dp_sts i_sts,
    output lphs_pkg::t_dp_ctl o_ctl
);
    import lphs_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_HOME    = 7'b0000100,
        ST_PROBE   = 7'b0001000,
        ST_DEL     = 7'b0010000,
        ST_DEL_END = 7'b0100000,
        ST_RESP    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_HOME;
                end
            end
            ST_HOME: begin
                if (i_sts.home_done) begin
                    o_ctl.probe_start = 1'b1;
                    n_state           = ST_PROBE;
                end
            end
            ST_PROBE: begin
                o_ctl.probe = 1'b1;
                if (i_sts.probe_stop) begin
                    n_state = i_sts.del_go ? ST_DEL : ST_RESP;
                end
            end
            ST_DEL: begin
                o_ctl.del = 1'b1;
                if (i_sts.del_stop) begin
                    n_state = ST_DEL_END;
                end
            end
            ST_DEL_END: begin
                o_ctl.del_end = 1'b1;
                n_state       = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: hdl/lphs_dp.sv
module lphs_dp #(
    parameter int TABLE_SLOTS = 64,
    parameter int TYPE_BITS   = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lphs_pkg::t_dp_ctl                     i_ctl,
    output lphs_pkg::t_dp_sts                     o_sts,
    input  logic [1:0]                            i_command,
    input  logic [lphs_pkg::KEY_TYPE_BITS-1:0]    i_key_type,
    input  logic [lphs_pkg::HASH_BITS-1:0]        i_key_hash,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic                                  o_found,
    output logic [lphs_pkg::SLOT_OUT_BITS-1:0]    o_slot,
    output logic                                  o_status,
    output logic [lphs_pkg::COUNT_OUT_BITS-1:0]   o_count
);
    import lphs_pkg::*;

    localparam int IW         = $clog2(TABLE_SLOTS);
    localparam int CW         = $clog2(TABLE_SLOTS + 1);
    localparam int LOAD_LIMIT = (TABLE_SLOTS * 2) / 3;
    localparam int CHUNKS     = HASH_BITS / CHUNK_BITS;
    localparam int STEP_W     = $clog2(CHUNKS);
    localparam bit IS_POW2    = (TABLE_SLOTS == (1 << IW));

    // One slot: home index is kept so the backward shift needs no reduction
    typedef struct packed {
        logic                 valid;
        logic [IW-1:0]        home;
        logic [TYPE_BITS-1:0] ktype;
        logic [HASH_BITS-1:0] hash;
    } t_entry;

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] a);
        if (a == IW'(TABLE_SLOTS - 1)) begin
            return '0;
        end
        return a + IW'(1);
    endfunction

    t_entry               r_mem [TABLE_SLOTS];
    t_entry               r_rd;
    logic [IW-1:0]        r_clr;
    t_command             r_cmd;
    logic [TYPE_BITS-1:0] r_type;
    logic [HASH_BITS-1:0] r_hash;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_n;
    logic [IW-1:0]        r_hole;
    logic [IW-1:0]        r_j;
    logic [IW-1:0]        r_dn;
    logic                 r_hit;
    logic [IW-1:0]        r_where;
    logic                 r_refused;
    logic [CW-1:0]        r_count;
    logic                 r_ovalid;
    logic                 r_ofound;
    logic [IW-1:0]        r_oslot;
    logic                 r_ostatus;
    logic [CW-1:0]        r_ocount;

    logic [IW-1:0]        w_home;
    logic                 w_home_done;
    logic                 w_empty;
    logic                 w_match;
    logic                 w_pstop;
    logic                 w_room;
    logic                 w_add_ok;
    logic                 w_del_go;
    logic                 w_move;
    logic                 w_dstop;
    logic [IW-1:0]        w_raddr;
    logic                 w_we;
    logic [IW-1:0]        w_waddr;
    t_entry               w_wdata;

    // Home slot: key hash reduced modulo the table size
    if (IS_POW2) begin : g_home_mask
        logic [IW-1:0] r_rem;

        always_ff @(posedge i_clk) begin
            if (i_ctl.load) begin
                r_rem <= i_key_hash[IW-1:0];
            end
        end

        assign w_home      = r_rem;
        assign w_home_done = 1'b1;
    end else begin : g_home_reduce
        logic [IW-1:0]        r_rem;
        logic [IW-1:0]        n_rem;
        logic [HASH_BITS-1:0] r_sh;
        logic [STEP_W-1:0]    r_step;
        logic                 r_busy;

        // Fold in one chunk, most significant bit first
        always_comb begin
            logic [IW:0] tmp;
            n_rem = r_rem;
            for (int b = 0; b < CHUNK_BITS; b++) begin
                tmp = {n_rem, r_sh[HASH_BITS-1-b]};
                if (tmp >= (IW+1)'(TABLE_SLOTS)) begin
                    tmp = tmp - (IW+1)'(TABLE_SLOTS);
                end
                n_rem = tmp[IW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
            end else if (i_ctl.load) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(CHUNKS - 1)) begin
                r_busy <= 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.load) begin
                r_sh   <= i_key_hash;
                r_rem  <= '0;
                r_step <= '0;
            end else if (r_busy) begin
                r_sh   <= r_sh << CHUNK_BITS;
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
            end
        end

        assign w_home      = r_rem;
        assign w_home_done = !r_busy;
    end

    // Probe chain: examine the slot read in the previous cycle
    assign w_empty  = !r_rd.valid;
    assign w_match  = r_rd.valid && (r_rd.ktype == r_type) && (r_rd.hash == r_hash);
    assign w_pstop  = w_empty || w_match || (r_n == IW'(TABLE_SLOTS - 1));
    assign w_room   = w_empty && (r_count < CW'(LOAD_LIMIT));
    assign w_add_ok = (r_cmd == CMD_ADD) && !w_match && w_room;
    assign w_del_go = (r_cmd == CMD_REMOVE) && w_match;

    // Backward shift: move the entry if its home does not lie between hole and slot
    always_comb begin
        if (r_j > r_hole) begin
            w_move = (r_rd.home <= r_hole) || (r_rd.home > r_j);
        end else begin
            w_move = (r_rd.home <= r_hole) && (r_rd.home > r_j);
        end
    end
    assign w_dstop = !r_rd.valid || (r_dn == IW'(TABLE_SLOTS - 1));

    // Table read address
    always_comb begin
        w_raddr = r_idx;
        if (i_ctl.probe_start) begin
            w_raddr = w_home;
        end else if (i_ctl.probe) begin
            w_raddr = f_inc(r_idx);
        end else if (i_ctl.del) begin
            w_raddr = f_inc(r_j);
        end
    end

    // Table write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_hole;
        w_wdata = '0;
        if (i_ctl.clear) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
        end else if (i_ctl.probe && w_pstop && w_add_ok) begin
            w_we          = 1'b1;
            w_waddr       = r_idx;
            w_wdata.valid = 1'b1;
            w_wdata.home  = w_home;
            w_wdata.ktype = r_type;
            w_wdata.hash  = r_hash;
        end else if (i_ctl.del && r_rd.valid && w_move) begin
            w_we    = 1'b1;
            w_wdata = r_rd;
        end else if (i_ctl.del_end) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctl.clear) begin
            r_clr <= f_inc(r_clr);
        end
    end

    // Request word and walk registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_command'(i_command);
            r_type <= TYPE_BITS'(i_key_type);
            r_hash <= i_key_hash;
        end
        if (i_ctl.probe_start) begin
            r_idx <= w_home;
            r_n   <= '0;
        end else if (i_ctl.probe) begin
            if (!w_pstop) begin
                r_idx <= f_inc(r_idx);
                r_n   <= r_n + IW'(1);
            end else begin
                r_hit     <= w_match;
                r_where   <= (w_empty || w_match) ? r_idx : w_home;
                r_refused <= (r_cmd == CMD_ADD) && !w_match && !w_room;
                r_hole    <= r_idx;
                r_j       <= f_inc(r_idx);
                r_dn      <= IW'(1);
            end
        end else if (i_ctl.del) begin
            if (r_rd.valid && w_move) begin
                r_hole <= r_j;
            end
            r_j  <= f_inc(r_j);
            r_dn <= r_dn + IW'(1);
        end
    end

    // Stored key count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.probe && w_pstop) begin
            if (w_add_ok) begin
                r_count <= r_count + CW'(1);
            end else if (w_del_go && r_count != '0) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Result register: hold the word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_ofound  <= r_hit;
            r_oslot   <= r_where;
            r_ostatus <= r_refused;
            r_ocount  <= r_count;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_found  = r_ofound;
    assign o_slot   = SLOT_OUT_BITS'(r_oslot);
    assign o_status = r_ostatus;
    assign o_count  = COUNT_OUT_BITS'(r_ocount);

    // Status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr == IW'(TABLE_SLOTS - 1));
        o_sts.home_done  = w_home_done;
        o_sts.probe_stop = w_pstop;
        o_sts.del_go     = w_del_go;
        o_sts.del_stop   = w_dstop;
        o_sts.out_free   = !r_ovalid || i_ready;
    end

endmodule

FILE: hdl/lphs_check.sv
module lphs_check (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic [1:0]                            i_command,
    input logic [lphs_pkg::KEY_TYPE_BITS-1:0]    i_key_type,
    input logic [lphs_pkg::HASH_BITS-1:0]        i_key_hash,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic                                  o_found,
    input logic [lphs_pkg::SLOT_OUT_BITS-1:0]    o_slot,
    input logic                                  o_status,
    input logic [lphs_pkg::COUNT_OUT_BITS-1:0]   o_count
);

    // Hold off requests while the clearing pass runs
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input ready high right after reset");

    // Drop ready once a word is taken: one request in flight
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while a request is in flight");

    // A refused add is always a miss
    a_refused_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_found)
        else $error("load-limit refusal reported on a key that was present");

    // Hold a stalled result word
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_slot)
            && $stable(o_status) && $stable(o_count))
        else $error("stalled result word changed");

endmodule

bind linear_probe_hash_set lphs_check u_lphs_check (.*);
